FILE: hdl/sclex_pkg.sv
// sclex_pkg: types and constants for the script lexer.
// Result word layout, lexer modes, token and error codes, keyword table.
// No dependencies.
package sclex_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
  } sclex_in_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [4:0]  token_kind;
    logic        [15:0] start_line;
    logic        [15:0] start_column;
    logic        [31:0] start_offset;
    logic        [15:0] token_length;
    logic signed [31:0] int_value;
    logic        [7:0]  text_char;
    logic        [1:0]  error_code;
    logic               last;
  } sclex_out_t;

  typedef struct packed {
    logic [1:0] n;
    sclex_out_t r0;
    sclex_out_t r1;
  } sclex_push_t;

  typedef enum logic [2:0] {
    M_IDLE       = 3'd0,
    M_COMMENT    = 3'd1,
    M_WORD       = 3'd2,
    M_INT        = 3'd3,
    M_INT_FROZEN = 3'd4,
    M_STRING     = 3'd5,
    M_ESCAPE     = 3'd6,
    M_HALT       = 3'd7
  } sclex_mode_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOI  = 1'b1;

  localparam logic [1:0] K_TOKEN = 2'd0;
  localparam logic [1:0] K_CHAR  = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  localparam logic [4:0] TK_EOF    = 5'd0;
  localparam logic [4:0] TK_LBRACE = 5'd1;
  localparam logic [4:0] TK_RBRACE = 5'd2;
  localparam logic [4:0] TK_BANG   = 5'd3;
  localparam logic [4:0] TK_KW0    = 5'd4;
  localparam logic [4:0] TK_STRING = 5'd20;
  localparam logic [4:0] TK_WORD   = 5'd21;
  localparam logic [4:0] TK_INT    = 5'd22;

  localparam logic [1:0] E_UNCLOSED = 2'd0;
  localparam logic [1:0] E_EOF_ESC  = 2'd1;
  localparam logic [1:0] E_BAD_ESC  = 2'd2;
  localparam logic [1:0] E_UNEXP    = 2'd3;

  localparam int KW_NUM  = 16;
  localparam int KW_MAXC = 10;

  localparam logic [KW_MAXC*8-1:0] KW_STR [KW_NUM] = '{
    "debug", "macro", "cmd", "run", "if", "else", "dup", "swap",
    "over", "rot", "fileexists", "direxists", "mkdir", "log", "error", "print"
  };
  localparam int KW_LEN [KW_NUM] = '{5, 5, 3, 3, 2, 4, 3, 4, 4, 3, 10, 9, 5, 3, 5, 5};

  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [KW_MAXC*8-1:0] lj;
    lj = KW_STR[k] << ((KW_MAXC - KW_LEN[k]) * 8);
    return lj[(KW_MAXC-1-i)*8 +: 8];
  endfunction

endpackage

FILE: hdl/sclex_fifo.sv
// sclex_fifo: four-word result queue, up to two words pushed per cycle.
// Depends on sclex_pkg.
module sclex_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sclex_pkg::sclex_push_t push,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sclex_pkg::sclex_out_t out_data
);
  sclex_pkg::sclex_out_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rp_r];
  assign room      = (cnt_r <= 3'd2);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt  = wp_r + push.n;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

FILE: hdl/sclex_core.sv
// sclex_core: lexer state and single-pass byte logic, up to two result words per byte.
// Depends on sclex_pkg.
module sclex_core #(
  parameter int KEYWORD_MAX_LEN = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  sclex_pkg::sclex_in_t   item,
  output sclex_pkg::sclex_push_t push
);
  localparam int IDXW = $clog2(KEYWORD_MAX_LEN);

  sclex_pkg::sclex_mode_t mode_r, mode_nxt;
  logic [15:0] line_r, line_nxt, col_r, col_nxt;
  logic [31:0] off_r, off_nxt;
  logic [15:0] tsl_r, tsl_nxt, tsc_r, tsc_nxt, len_r, len_nxt;
  logic [31:0] tso_r, tso_nxt, acc_r, acc_nxt;
  logic        neg_r, neg_nxt, quote_r, quote_nxt;
  logic [7:0]  buf_r [KEYWORD_MAX_LEN];

  logic [7:0]  b;
  logic        eoi, is_sp, is_al, is_dg, is_nl;
  logic [15:0] len_inc;
  logic [4:0]  word_tk;
  logic        kw_m;
  logic [31:0] int_val;
  sclex_pkg::sclex_out_t tok_word, tok_int, here_err;

  // idle path
  logic        i_has, i_adv, i_start, i_bufw, i_int, i_quote;
  sclex_pkg::sclex_mode_t i_mode;
  sclex_pkg::sclex_out_t  i_res;

  logic        adv, start, grow, bufw, acc_upd, use_idle;
  logic [IDXW-1:0] widx;
  logic [1:0]  n;
  sclex_pkg::sclex_out_t r0, r1;
  logic [7:0]  dch;
  logic        esc_ok;

  assign b     = item.char_byte;
  assign eoi   = (item.op == sclex_pkg::OP_EOI);
  assign is_sp = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  assign is_al = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  assign is_dg = (b >= "0" && b <= "9");
  assign is_nl = (b == 8'h0a);
  assign len_inc = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
  assign int_val = neg_r ? (32'd0 - acc_r) : acc_r;

  always_comb begin
    word_tk = sclex_pkg::TK_WORD;
    for (int k = 0; k < sclex_pkg::KW_NUM; k++) begin
      kw_m = (len_r == 16'(sclex_pkg::KW_LEN[k]));
      for (int i = 0; i < sclex_pkg::KW_MAXC; i++) begin
        if (i < sclex_pkg::KW_LEN[k] && buf_r[i] != sclex_pkg::kw_char(k, i)) begin
          kw_m = 1'b0;
        end
      end
      if (kw_m) begin
        word_tk = sclex_pkg::TK_KW0 + 5'(k);
      end
    end
  end

  always_comb begin
    tok_word = '0;
    tok_word.kind         = sclex_pkg::K_TOKEN;
    tok_word.token_kind   = word_tk;
    tok_word.start_line   = tsl_r;
    tok_word.start_column = tsc_r;
    tok_word.start_offset = tso_r;
    tok_word.token_length = len_r;
    tok_int = tok_word;
    tok_int.token_kind = sclex_pkg::TK_INT;
    tok_int.int_value  = int_val;
    here_err = '0;
    here_err.kind         = sclex_pkg::K_ERROR;
    here_err.start_line   = line_r;
    here_err.start_column = col_r;
    here_err.start_offset = off_r;
  end

  always_comb begin
    i_has = 1'b0; i_adv = 1'b0; i_start = 1'b0; i_bufw = 1'b0;
    i_int = 1'b0; i_quote = 1'b0; i_mode = sclex_pkg::M_IDLE;
    i_res = '0;
    i_res.kind         = sclex_pkg::K_TOKEN;
    i_res.start_line   = line_r;
    i_res.start_column = col_r;
    i_res.start_offset = off_r;
    i_res.token_length = 16'd1;
    if (is_sp) begin
      i_adv = 1'b1;
    end else if (b == "#") begin
      i_mode = sclex_pkg::M_COMMENT;
      i_adv  = 1'b1;
    end else if (b == "{" || b == "}" || b == "!") begin
      i_has = 1'b1;
      i_adv = 1'b1;
      i_res.token_kind = (b == "{") ? sclex_pkg::TK_LBRACE :
                         (b == "}") ? sclex_pkg::TK_RBRACE : sclex_pkg::TK_BANG;
    end else if (is_al) begin
      i_start = 1'b1; i_bufw = 1'b1; i_adv = 1'b1; i_mode = sclex_pkg::M_WORD;
    end else if (is_dg || b == "-") begin
      i_start = 1'b1; i_int = 1'b1; i_adv = 1'b1; i_mode = sclex_pkg::M_INT;
    end else if (b == "\"" || b == "'") begin
      i_start = 1'b1; i_quote = 1'b1; i_adv = 1'b1; i_mode = sclex_pkg::M_STRING;
    end else begin
      i_has = 1'b1;
      i_res = here_err;
      i_res.error_code = sclex_pkg::E_UNEXP;
      i_mode = sclex_pkg::M_HALT;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    adv = 1'b0; start = 1'b0; grow = 1'b0; bufw = 1'b0; acc_upd = 1'b0;
    use_idle = 1'b0; widx = '0; n = 2'd0; r0 = '0; r1 = '0;
    dch = 8'd0; esc_ok = 1'b1;
    if (mode_r == sclex_pkg::M_HALT) begin
      n = 2'd0;
    end else if (eoi) begin
      if (mode_r == sclex_pkg::M_WORD) begin
        r0 = tok_word; n = 2'd1;
      end else if (mode_r == sclex_pkg::M_INT || mode_r == sclex_pkg::M_INT_FROZEN) begin
        r0 = tok_int; n = 2'd1;
      end
      if (mode_r == sclex_pkg::M_STRING || mode_r == sclex_pkg::M_ESCAPE) begin
        r0 = '0;
        r0.kind         = sclex_pkg::K_ERROR;
        r0.start_line   = tsl_r;
        r0.start_column = tsc_r;
        r0.start_offset = tso_r;
        r0.error_code   = (mode_r == sclex_pkg::M_STRING) ? sclex_pkg::E_UNCLOSED :
                                                            sclex_pkg::E_EOF_ESC;
        n = 2'd1;
      end else begin
        r1 = '0;
        r1.kind         = sclex_pkg::K_TOKEN;
        r1.token_kind   = sclex_pkg::TK_EOF;
        r1.start_line   = line_r;
        r1.start_column = col_r;
        r1.start_offset = off_r;
        if (n == 2'd0) begin
          r0 = r1; n = 2'd1;
        end else begin
          n = 2'd2;
        end
      end
      mode_nxt = sclex_pkg::M_HALT;
    end else begin
      unique case (mode_r)
        sclex_pkg::M_COMMENT: begin
          adv = 1'b1;
          if (is_nl) mode_nxt = sclex_pkg::M_IDLE;
        end
        sclex_pkg::M_STRING: begin
          if (b == (quote_r ? 8'h27 : 8'h22)) begin
            grow = 1'b1; adv = 1'b1; mode_nxt = sclex_pkg::M_IDLE;
            r0 = tok_word;
            r0.token_kind   = sclex_pkg::TK_STRING;
            r0.token_length = len_inc;
            n = 2'd1;
          end else if (b == 8'h5c) begin
            grow = 1'b1; adv = 1'b1; mode_nxt = sclex_pkg::M_ESCAPE;
          end else if (is_nl) begin
            r0 = here_err; r0.error_code = sclex_pkg::E_UNCLOSED; n = 2'd1;
            mode_nxt = sclex_pkg::M_HALT;
          end else begin
            grow = 1'b1; adv = 1'b1;
            r0.kind = sclex_pkg::K_CHAR; r0.text_char = b; n = 2'd1;
          end
        end
        sclex_pkg::M_ESCAPE: begin
          priority if (b == "r") dch = 8'h0d;
          else if (b == "n") dch = 8'h0a;
          else if (b == "t") dch = 8'h09;
          else if (b == 8'h22 || b == 8'h27) dch = b;
          else esc_ok = 1'b0;
          if (esc_ok) begin
            grow = 1'b1; adv = 1'b1; mode_nxt = sclex_pkg::M_STRING;
            r0.kind = sclex_pkg::K_CHAR; r0.text_char = dch; n = 2'd1;
          end else begin
            r0 = here_err; r0.error_code = sclex_pkg::E_BAD_ESC; n = 2'd1;
            mode_nxt = sclex_pkg::M_HALT;
          end
        end
        sclex_pkg::M_WORD: begin
          if (is_al || is_dg) begin
            grow = 1'b1; adv = 1'b1;
            if (len_r < 16'(KEYWORD_MAX_LEN)) begin
              bufw = 1'b1; widx = len_r[IDXW-1:0];
            end
          end else begin
            r0 = tok_word; n = 2'd1; use_idle = 1'b1;
          end
        end
        sclex_pkg::M_INT, sclex_pkg::M_INT_FROZEN: begin
          if (is_dg || b == "-") begin
            grow = 1'b1; adv = 1'b1;
            if (b == "-") mode_nxt = sclex_pkg::M_INT_FROZEN;
            else if (mode_r == sclex_pkg::M_INT) acc_upd = 1'b1;
          end else begin
            r0 = tok_int; n = 2'd1; use_idle = 1'b1;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase
      if (use_idle) begin
        mode_nxt = i_mode; adv = i_adv; start = i_start;
        if (i_bufw) begin
          bufw = 1'b1; widx = '0;
        end
        if (i_has) begin
          if (n == 2'd0) begin
            r0 = i_res; n = 2'd1;
          end else begin
            r1 = i_res; n = 2'd2;
          end
        end
      end
    end
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_comb begin
    line_nxt = line_r; col_nxt = col_r; off_nxt = off_r;
    if (adv) begin
      off_nxt = off_r + 32'd1;
      if (is_nl) begin
        line_nxt = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
        col_nxt  = 16'd0;
      end else begin
        col_nxt = (col_r == 16'hFFFF) ? col_r : col_r + 16'd1;
      end
    end
    tsl_nxt = start ? line_r : tsl_r;
    tsc_nxt = start ? col_r : tsc_r;
    tso_nxt = start ? off_r : tso_r;
    len_nxt = start ? 16'd1 : (grow ? len_inc : len_r);
    acc_nxt = acc_r; neg_nxt = neg_r; quote_nxt = quote_r;
    if (use_idle && i_int) begin
      neg_nxt = (b == "-");
      acc_nxt = is_dg ? {28'd0, b[3:0]} : 32'd0;
    end
    if (acc_upd) acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, b[3:0]};
    if (use_idle && i_quote) quote_nxt = (b == 8'h27);
  end

  always_comb begin
    push    = '0;
    push.n  = fire ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (fire && bufw) begin
      buf_r[widx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sclex_pkg::M_IDLE;
      line_r <= '0; col_r <= '0; off_r <= '0;
      tsl_r <= '0; tsc_r <= '0; tso_r <= '0;
      len_r <= '0; acc_r <= '0; neg_r <= 1'b0; quote_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt;
      tsl_r <= tsl_nxt; tsc_r <= tsc_nxt; tso_r <= tso_nxt;
      len_r <= len_nxt; acc_r <= acc_nxt; neg_r <= neg_nxt; quote_r <= quote_nxt;
    end
  end
endmodule

FILE: hdl/script_lexer_byte_stream.sv
// Script lexer top level: input word register, lexer core, result queue.
// Path: a byte is held in the input word register until the queue has room, then
// the core writes its result words into the queue, which drives out_data.
// Throughput: one input word per cycle while the four-word result queue holds
// at most two words; an item yields zero to two result words.
// Reset (rst_n, synchronous): lexer idle at line 0, column 0, offset 0; queue empty.
// Depends on sclex_pkg, sclex_core, sclex_fifo.
module script_lexer_byte_stream #(
  parameter int KEYWORD_MAX_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sclex_pkg::sclex_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sclex_pkg::sclex_out_t out_data
);
  sclex_pkg::sclex_in_t  stg_r;
  logic                  stg_v_r, stg_v_nxt;
  logic                  room, fire, in_acc;
  sclex_pkg::sclex_push_t push;

  assign fire     = stg_v_r && room;
  assign in_stall = stg_v_r && !room;
  assign in_acc   = in_valid && !in_stall;
  assign stg_v_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : stg_v_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  sclex_core #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (stg_r),
    .push (push)
  );

  sclex_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );
endmodule

FILE: hdl/sclex_checker.sv
// sclex_checker: port-level assertions for the script lexer, bound to the top level.
// Depends on sclex_pkg and script_lexer_byte_stream.
module sclex_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sclex_pkg::sclex_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sclex_pkg::sclex_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind != 2'd3)
    else $error("bad result kind");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == sclex_pkg::K_ERROR || out_data.kind == sclex_pkg::K_CHAR)
    |-> out_data.last)
    else $error("error or char word not last");

  a_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid) && !$past(in_stall) |-> !in_stall)
    else $error("stall with empty input register");
endmodule

bind script_lexer_byte_stream sclex_checker u_sclex_checker (.*);
